>>> hw/rtl/timed_valve_sequencer_macros.svh
// Assertion macros used by the checker file
`ifndef TIMED_VALVE_SEQUENCER_MACROS_SVH
`define TIMED_VALVE_SEQUENCER_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define TVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define TVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Types and constants for the timed valve sequencer.
// ----------------------------------------------------------------------------
package tvs_pkg;
  localparam int NUM_VALVES      = 5;
  localparam int PERMANENT_VALVE = 4;
  localparam logic [31:0] DEFAULT_OPEN_MS = 32'd5000;
  localparam int VW = 3;
  localparam logic [39:0] MAX_TIME = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] FULL_OPEN = 16'd32768;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_TOGGLE = 3'd1, OP_TIMED = 3'd2, OP_CLOSE_ALL = 3'd3,
    OP_WIGGLE = 3'd4, OP_SET_AP = 3'd5, OP_SET_TIME = 3'd6, OP_BAD = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_POS = 3'd0, K_OPEN = 3'd1, K_CLOSE = 3'd2, K_BUS = 3'd3,
    K_ACK = 3'd4, K_REJ = 3'd5
  } kind_t;

  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_CONF   = 2'd1;
  localparam logic [1:0] REG_WIGGLE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TICK_CHK, S_TICK_CLOSE, S_TICK_POS,
    S_SHUT_CHK, S_FLIP_EVT, S_FLIP_BUS, S_ACK, S_REJ, S_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic         load;       // capture request
    logic         set_idx;    // idx <= value below
    logic [VW-1:0] idx_val;
    logic         inc_idx;
    logic         close_idx;  // deadline 0, change time now
    logic         open_idx;   // deadline now+dur, change time now
    logic         wr_ap;
    logic         wr_dur;
    logic         emit;
    kind_t        kind;
    logic         use_req_valve;
    logic         bus_open;
    logic         last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t          op;
    logic         valve_ok;
    logic [VW-1:0] idx;
    logic         idx_open;   // deadline nonzero
    logic         idx_live;   // deadline > now
    logic         req_open;   // requested valve deadline nonzero
    logic         out_busy;   // output register full and stalled
  } stat_t;
endpackage

>>> hw/rtl/tvs_datapath.sv
// ----------------------------------------------------------------------------
// tvs_datapath
// Valve state registers, request capture, position math and result register.
// ----------------------------------------------------------------------------
module tvs_datapath import tvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_valve,
  input  logic [39:0] in_now_ms,
  input  logic [31:0] in_operand,
  input  logic [15:0] settle_r,
  input  logic [15:0] conf_r,
  input  logic [31:0] wiggle_r,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_valve_out,
  output logic [15:0] out_position,
  output logic        out_bus_open,
  output logic [31:0] out_bus_duration,
  output logic        out_last
);
  logic [39:0] dl_r [NUM_VALVES];
  logic [39:0] ct_r [NUM_VALVES];
  logic [15:0] ap_r [NUM_VALVES];
  logic [31:0] dur_r [NUM_VALVES];
  logic [2:0]  op_r, vlv_r;
  logic [39:0] now_r;
  logic [31:0] arg_r;
  logic [VW-1:0] idx_r;
  logic [31:0] kept_prod_r;
  logic        vok;
  logic [VW-1:0] fv;   // valve used by a flip, else the indexed valve
  logic [31:0] fdur;
  logic [40:0] dsum;
  logic [39:0] dnew;
  logic [40:0] ctsum;
  logic        settled;
  logic [15:0] kept, pos;

  assign vok = ({1'b0, vlv_r} < 4'(NUM_VALVES));
  assign fv  = cmd.use_req_valve ? vlv_r : idx_r;
  always_comb begin
    case (op_t'(op_r))
      OP_TOGGLE: fdur = dur_r[fv];
      OP_WIGGLE: fdur = wiggle_r;
      default:   fdur = arg_r;
    endcase
  end
  assign dsum = {1'b0, now_r} + {9'd0, fdur};
  assign dnew = dsum[40] ? MAX_TIME : dsum[39:0];

  // Position of the indexed valve; product registered every cycle from the indexed valve
  assign kept = kept_prod_r[31:16];
  assign ctsum = {1'b0, ct_r[idx_r]} + {25'd0, settle_r};
  assign settled = {1'b0, now_r} > ctsum;
  always_comb begin
    if (dl_r[idx_r] > now_r) pos = settled ? ap_r[idx_r] - kept : ap_r[idx_r];
    else                     pos = settled ? kept : 16'd0;
  end

  // Request capture and index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode; vlv_r <= in_valve; now_r <= in_now_ms; arg_r <= in_operand;
    end
    kept_prod_r <= ap_r[idx_r] * conf_r;
    if (!rst_n) idx_r <= '0;
    else if (cmd.set_idx) idx_r <= cmd.idx_val;
    else if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
  end

  // Valve state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VALVES; i++) begin
        dl_r[i] <= '0; ct_r[i] <= '0; ap_r[i] <= FULL_OPEN; dur_r[i] <= DEFAULT_OPEN_MS;
      end
    end else begin
      if (cmd.close_idx) begin dl_r[fv] <= '0; ct_r[fv] <= now_r; end
      if (cmd.open_idx)  begin dl_r[fv] <= dnew; ct_r[fv] <= now_r; end
      if (cmd.wr_ap) ap_r[vlv_r] <= (arg_r > 32'(FULL_OPEN)) ? FULL_OPEN : arg_r[15:0];
      if (cmd.wr_dur) dur_r[vlv_r] <= arg_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.emit) begin
      out_kind         <= cmd.kind;
      out_valve_out    <= (cmd.kind == K_ACK && op_t'(op_r) == OP_CLOSE_ALL) ? 3'd0 :
                          (cmd.use_req_valve ? vlv_r : 3'(idx_r));
      out_position     <= (cmd.kind == K_POS) ? pos : 16'd0;
      out_bus_open     <= cmd.bus_open;
      out_bus_duration <= cmd.bus_open ? fdur : 32'd0;
      out_last         <= cmd.last;
    end
  end

  assign stat.op       = op_t'(op_r);
  assign stat.valve_ok = vok;
  assign stat.idx      = idx_r;
  assign stat.idx_open = dl_r[idx_r] != '0;
  assign stat.idx_live = dl_r[idx_r] > now_r;
  assign stat.req_open = dl_r[vlv_r] != '0;
  assign stat.out_busy = out_valid && out_stall;
endmodule

>>> hw/rtl/tvs_ctrl.sv
// ----------------------------------------------------------------------------
// tvs_ctrl
// Sequencer that walks valves and issues one result at a time.
// ----------------------------------------------------------------------------
module tvs_ctrl import tvs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   is_last_idx, shut_hit;
  logic   flip_closed_r;

  assign is_last_idx = ({1'b0, stat.idx} == 4'(NUM_VALVES - 1));
  assign shut_hit    = stat.idx_open && ({1'b0, stat.idx} != 4'(PERMANENT_VALVE));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.op)
          OP_TICK:      state_nxt = S_WAIT;
          OP_CLOSE_ALL: state_nxt = S_SHUT_CHK;
          default: begin
            if (stat.op == OP_BAD || !stat.valve_ok) state_nxt = S_REJ;
            else if (stat.op == OP_WIGGLE)             state_nxt = S_SHUT_CHK;
            else if (stat.op == OP_SET_AP || stat.op == OP_SET_TIME) state_nxt = S_ACK;
            else                                        state_nxt = S_FLIP_EVT;
          end
        endcase
      end
      S_WAIT: state_nxt = S_TICK_CHK;
      S_TICK_CHK: if (!stat.idx_live && stat.idx_open) state_nxt = S_TICK_CLOSE;
                  else state_nxt = S_TICK_POS;
      S_TICK_CLOSE: if (!stat.out_busy) state_nxt = S_TICK_POS;
      S_TICK_POS: if (!stat.out_busy) state_nxt = is_last_idx ? S_IDLE : S_WAIT;
      S_SHUT_CHK: if (!stat.out_busy && is_last_idx) begin
        state_nxt = (stat.op == OP_WIGGLE) ? S_FLIP_EVT : S_ACK;
      end
      S_FLIP_EVT: if (!stat.out_busy) state_nxt = S_FLIP_BUS;
      S_FLIP_BUS: if (!stat.out_busy) state_nxt = S_IDLE;
      S_ACK:      if (!stat.out_busy) state_nxt = S_IDLE;
      S_REJ:      if (!stat.out_busy) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.kind = K_POS;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid; cmd.set_idx = 1'b1; cmd.idx_val = '0;
      end
      S_TICK_CLOSE: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.kind = K_CLOSE; cmd.close_idx = 1'b1;
      end
      S_TICK_POS: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.kind = K_POS; cmd.last = is_last_idx; cmd.inc_idx = 1'b1;
      end
      S_SHUT_CHK: if (!stat.out_busy) begin
        cmd.inc_idx = 1'b1;
        if (shut_hit) begin
          cmd.emit = 1'b1; cmd.kind = K_BUS; cmd.close_idx = 1'b1;
        end
      end
      S_FLIP_EVT: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.use_req_valve = 1'b1;
        cmd.kind = stat.req_open ? K_CLOSE : K_OPEN;
      end
      S_FLIP_BUS: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.use_req_valve = 1'b1; cmd.kind = K_BUS; cmd.last = 1'b1;
        // deadline zero now means it was just closed in the event step
        if (stat.req_open) cmd.close_idx = 1'b0;
        cmd.bus_open = !flip_closed_r;
      end
      S_ACK: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.use_req_valve = 1'b1; cmd.kind = K_ACK; cmd.last = 1'b1;
        cmd.wr_ap  = (stat.op == OP_SET_AP);
        cmd.wr_dur = (stat.op == OP_SET_TIME);
      end
      S_REJ: if (!stat.out_busy) begin
        cmd.emit = 1'b1; cmd.use_req_valve = 1'b1; cmd.kind = K_REJ; cmd.last = 1'b1;
      end
      default: ;
    endcase
    // Flip state change happens with the event
    if (state_r == S_FLIP_EVT && !stat.out_busy) begin
      cmd.close_idx = stat.req_open;
      cmd.open_idx  = !stat.req_open;
    end
  end

  // Remember flip direction for the bus command
  always_ff @(posedge clk) begin
    if (state_r == S_FLIP_EVT) flip_closed_r <= stat.req_open;
  end
endmodule

>>> hw/rtl/timed_valve_sequencer.sv
// ----------------------------------------------------------------------------
// timed_valve_sequencer
// Timed valve controller: commands, ticks with per-valve positions.
// ----------------------------------------------------------------------------
// channel | ports                               | direction
// in      | in_valid/in_stall + 4 fields        | request in
// out     | out_valid/out_stall + 6 fields      | results out
// cfg     | psel/penable/pwrite/paddr/pwdata    | register access
// A tick walks each valve through the wait, check and position states, plus a close per event.
// Close all walks every valve, one per cycle while the output does not stall.
// One result leaves the output register per cycle; a stall holds the walk.
// Synchronous active-low reset; all valves closed after reset.
module timed_valve_sequencer import tvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_valve,
  input  logic [39:0] in_now_ms,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_valve_out,
  output logic [15:0] out_position,
  output logic        out_bus_open,
  output logic [31:0] out_bus_duration,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t  cmd;
  stat_t stat;
  logic [15:0] settle_r, conf_r;
  logic [31:0] wiggle_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 16'd500; conf_r <= 16'd1311; wiggle_r <= 32'd1000;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[3:2] == REG_SETTLE) settle_r <= pwdata[15:0];
      if (paddr[3:2] == REG_CONF)   conf_r   <= pwdata[15:0];
      if (paddr[3:2] == REG_WIGGLE) wiggle_r <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SETTLE: prdata = {16'd0, settle_r};
      REG_CONF:   prdata = {16'd0, conf_r};
      REG_WIGGLE: prdata = wiggle_r;
      default:    prdata = 32'd0;
    endcase
  end

  tvs_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .stat, .cmd);

  tvs_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_opcode, .in_valve, .in_now_ms, .in_operand,
    .settle_r, .conf_r, .wiggle_r, .out_valid, .out_stall, .out_kind, .out_valve_out,
    .out_position, .out_bus_open, .out_bus_duration, .out_last
  );
endmodule

>>> hw/rtl/tvs_checker.sv
// ----------------------------------------------------------------------------
// tvs_checker
// Port-level checks of the valve sequencer.
// ----------------------------------------------------------------------------
`include "timed_valve_sequencer_macros.svh"
module tvs_checker import tvs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [15:0] out_position,
  input logic        out_bus_open,
  input logic [31:0] out_bus_duration
);
  `TVS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `TVS_ASSERT_IMP(a_pos_range, clk, rst_n, out_valid, out_position <= FULL_OPEN)
  `TVS_ASSERT_IMP(a_bus_only, clk, rst_n, out_valid && out_kind != K_BUS, !out_bus_open)
  `TVS_ASSERT_IMP(a_dur_zero, clk, rst_n, out_valid && !out_bus_open, out_bus_duration == 32'd0)
  `TVS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind timed_valve_sequencer tvs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_kind,
  .out_position, .out_bus_open, .out_bus_duration
);
